[rtl/core/dsv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_pkg
// Shared types, constants and helpers for the date string validator.
// ----------------------------------------------------------------------------
package dsv_pkg;

  localparam int unsigned FIELD_BITS = 16;
  localparam int unsigned ACC_W      = FIELD_BITS + 4;
  localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

  // year mod 25 of the saturated accumulator
  localparam logic [4:0] SAT_MOD25 =
    5'(((64'd1 << FIELD_BITS) - 64'd1) % 64'd25);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  localparam logic [1:0] DOTS_DAY   = 2'd0;
  localparam logic [1:0] DOTS_MONTH = 2'd1;
  localparam logic [1:0] DOTS_YEAR  = 2'd2;

  localparam int unsigned SEEN_DAY   = 0;
  localparam int unsigned SEEN_MONTH = 1;
  localparam int unsigned SEEN_YEAR  = 2;

  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_BAD_CHAR    = 4'd1,
    ERR_MANY_DOTS   = 4'd2,
    ERR_FEW_DOTS    = 4'd3,
    ERR_EMPTY_MONTH = 4'd4,
    ERR_MONTH_RANGE = 4'd5,
    ERR_DAY_RANGE   = 4'd6,
    ERR_DAY_OVER    = 4'd7,
    ERR_EMPTY_FIELD = 4'd8
  } err_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic        date_ok;
    logic [3:0]  error_kind;
    logic [15:0] day_value;
    logic [15:0] month_value;
    logic [15:0] year_value;
  } out_item_t;

  // finished string handed from the parser to the verdict stage
  typedef struct packed {
    err_t                  first_error;
    logic [1:0]            dots;
    logic [2:0]            seen;
    logic [FIELD_BITS-1:0] day;
    logic [FIELD_BITS-1:0] month;
    logic [FIELD_BITS-1:0] year;
    logic [4:0]            year_mod25;
  } rec_t;

  // v < 250: quotient by 25 through reciprocal 41/1024
  function automatic logic [4:0] mod25(input logic [7:0] v);
    logic [13:0] prod;
    logic [3:0]  q;
    logic [7:0]  qx25;
    begin
      prod = 14'(v) * 14'd41;
      q    = prod[13:10];
      qx25 = 8'(q) * 8'd25;
      mod25 = 5'(v - qx25);
    end
  endfunction

endpackage

[rtl/core/dsv_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_front
// Character parser: accumulates day, month and year, counts dots and keeps
// the first error; pushes a record on the last character and clears.
// ----------------------------------------------------------------------------
module dsv_front
  import dsv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     rec_push,
  output rec_t     rec
);

  logic [1:0]            dots_r, dots_nxt;
  logic [2:0]            seen_r, seen_nxt;
  err_t                  err_r, err_nxt;
  logic [FIELD_BITS-1:0] day_r, day_nxt;
  logic [FIELD_BITS-1:0] month_r, month_nxt;
  logic [FIELD_BITS-1:0] year_r, year_nxt;
  logic [4:0]            ymod_r, ymod_nxt;

  logic                  accept;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [FIELD_BITS-1:0] acc_sel;
  logic [ACC_W-1:0]      acc_ext;
  logic [ACC_W-1:0]      acc_sum;
  logic                  acc_sat;
  logic [FIELD_BITS-1:0] acc_new;
  logic [7:0]            ymod_sum;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  assign is_digit = (in_data.char_code >= CHAR_ZERO) && (in_data.char_code <= CHAR_NINE);
  assign digit    = 4'(in_data.char_code - CHAR_ZERO);

  always_comb begin
    case (dots_r)
      DOTS_DAY:   acc_sel = day_r;
      DOTS_MONTH: acc_sel = month_r;
      default:    acc_sel = year_r;
    endcase
  end

  // acc * 10 + digit, held at the field maximum
  assign acc_ext  = ACC_W'(acc_sel);
  assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(digit);
  assign acc_sat  = acc_sum > ACC_W'(FIELD_MAX);
  assign acc_new  = acc_sat ? FIELD_MAX : acc_sum[FIELD_BITS-1:0];
  assign ymod_sum = (8'(ymod_r) << 3) + (8'(ymod_r) << 1) + 8'(digit);

  always_comb begin
    dots_nxt  = dots_r;
    seen_nxt  = seen_r;
    err_nxt   = err_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    ymod_nxt  = ymod_r;
    if (is_digit) begin
      case (dots_r)
        DOTS_DAY: begin
          day_nxt            = acc_new;
          seen_nxt[SEEN_DAY] = 1'b1;
        end
        DOTS_MONTH: begin
          month_nxt            = acc_new;
          seen_nxt[SEEN_MONTH] = 1'b1;
        end
        default: begin
          year_nxt            = acc_new;
          seen_nxt[SEEN_YEAR] = 1'b1;
          ymod_nxt            = acc_sat ? SAT_MOD25 : mod25(ymod_sum);
        end
      endcase
    end else if (in_data.char_code == CHAR_DOT) begin
      if (dots_r == DOTS_YEAR) begin
        if (err_r == ERR_NONE) err_nxt = ERR_MANY_DOTS;
      end else begin
        dots_nxt = dots_r + 2'd1;
      end
    end else begin
      if (err_r == ERR_NONE) err_nxt = ERR_BAD_CHAR;
    end
  end

  assign rec_push         = accept && in_data.last_char;
  assign rec.first_error  = err_nxt;
  assign rec.dots         = dots_nxt;
  assign rec.seen         = seen_nxt;
  assign rec.day          = day_nxt;
  assign rec.month        = month_nxt;
  assign rec.year         = year_nxt;
  assign rec.year_mod25   = ymod_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || rec_push) begin
      dots_r  <= DOTS_DAY;
      seen_r  <= '0;
      err_r   <= ERR_NONE;
      day_r   <= '0;
      month_r <= '0;
      year_r  <= '0;
      ymod_r  <= '0;
    end else if (accept) begin
      dots_r  <= dots_nxt;
      seen_r  <= seen_nxt;
      err_r   <= err_nxt;
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      ymod_r  <= ymod_nxt;
    end
  end

`ifndef SYNTHESIS
  a_dots_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dots_r != 2'd3)
    else $error("dot count out of range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push |=> (dots_r == DOTS_DAY && seen_r == 3'd0 && err_r == ERR_NONE))
    else $error("parser not cleared after last character");
`endif

endmodule

[rtl/core/dsv_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_queue
// Short record queue between the parser and the verdict stage.
// ----------------------------------------------------------------------------
module dsv_queue
  import dsv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output rec_t head
);

  rec_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = cnt_r == QCNT_W'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("record pushed into full queue");
`endif

endmodule

[rtl/core/dsv_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_back
// Verdict stage: checks one finished record and holds the result until
// it is taken.
// ----------------------------------------------------------------------------
module dsv_back
  import dsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      rec_valid,
  input  rec_t      rec,
  output logic      rec_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic      vld_r;
  out_item_t res_r, res_nxt;
  err_t      verdict;
  logic      leap;
  logic      month_30;
  logic      load;

  // leap: divisible by 4, and not by 100 unless by 400
  assign leap = (rec.year[1:0] == 2'd0) &&
                ((rec.year_mod25 != 5'd0) || (rec.year[3:0] == 4'd0));
  assign month_30 = (rec.month == FIELD_BITS'(4)) || (rec.month == FIELD_BITS'(6)) ||
                    (rec.month == FIELD_BITS'(9)) || (rec.month == FIELD_BITS'(11));

  always_comb begin
    if (rec.first_error != ERR_NONE)
      verdict = rec.first_error;
    else if (rec.dots != DOTS_YEAR)
      verdict = ERR_FEW_DOTS;
    else if (!rec.seen[SEEN_MONTH])
      verdict = ERR_EMPTY_MONTH;
    else if (!rec.seen[SEEN_DAY] || !rec.seen[SEEN_YEAR])
      verdict = ERR_EMPTY_FIELD;
    else if (rec.month == '0 || rec.month > FIELD_BITS'(12))
      verdict = ERR_MONTH_RANGE;
    else if (rec.day == '0 || rec.day > FIELD_BITS'(31))
      verdict = ERR_DAY_RANGE;
    else if (rec.month == FIELD_BITS'(2) &&
             rec.day > (leap ? FIELD_BITS'(29) : FIELD_BITS'(28)))
      verdict = ERR_DAY_OVER;
    else if (month_30 && rec.day > FIELD_BITS'(30))
      verdict = ERR_DAY_OVER;
    else
      verdict = ERR_NONE;
  end

  assign res_nxt.date_ok     = verdict == ERR_NONE;
  assign res_nxt.error_kind  = verdict;
  assign res_nxt.day_value   = 16'(rec.day);
  assign res_nxt.month_value = 16'(rec.month);
  assign res_nxt.year_value  = 16'(rec.year);

  // output slot frees when empty or drained in the same cycle
  assign load      = rec_valid && (!vld_r || out_pop);
  assign rec_pop   = load;
  assign out_empty = !vld_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_pop) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res_nxt;
  end

`ifndef SYNTHESIS
  a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (res_r.date_ok == (res_r.error_kind == ERR_NONE)))
    else $error("date_ok disagrees with error code");
`endif

endmodule

[rtl/core/date_string_validator.sv]
`timescale 1ns / 1ps
// path: the record finished by a last character is written into the record queue, then registered into the output slot
// throughput: one character per cycle while in_full is low; one result per cycle when out_pop stays high
// the two-entry record queue and the output register decouple input from result stalls
// reset: synchronous active-low rst_n clears parser state, the queue and the output slot
// ----------------------------------------------------------------------------
// date_string_validator
// Validates day.month.year strings fed one character per transfer.
// ----------------------------------------------------------------------------
module date_string_validator
  import dsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic rec_push, q_full, q_empty, rec_pop;
  rec_t rec_in, rec_head;

  dsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .q_full   (q_full),
    .rec_push (rec_push),
    .rec      (rec_in)
  );

  dsv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (rec_in),
    .full      (q_full),
    .pop       (rec_pop),
    .empty     (q_empty),
    .head      (rec_head)
  );

  dsv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (!q_empty),
    .rec       (rec_head),
    .rec_pop   (rec_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
